>>> design/zero_suppression_unpacker_macros.svh
// ----------------------------------------------------------------------------
// zero suppression unpacker assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef ZERO_SUPPRESSION_UNPACKER_MACROS_SVH
`define ZERO_SUPPRESSION_UNPACKER_MACROS_SVH

// plain property, sampled on clk_i, off while in reset
`define ZSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication, sampled on clk_i, off while in reset
`define ZSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define ZSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/zsu_pkg.sv
// ----------------------------------------------------------------------------
// zsu_pkg
// shared constants and types of the zero suppression unpacker
// ----------------------------------------------------------------------------
package zsu_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 20;
  localparam int unsigned PACKED_LENGTH_W = 20;
  localparam int unsigned OUTPUT_LIMIT_W  = 24;
  localparam int unsigned CFG_DATA_W      = 24;
  localparam int unsigned CFG_INDEX_W     = 2;
  localparam int unsigned RUN_W           = 11;
  localparam int unsigned RES_FIFO_DEPTH  = 4;

  localparam logic [OUTPUT_LIMIT_W-1:0] OUTPUT_LIMIT_RESET = 24'd8388608;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PACKED_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT  = 2'd1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;

  typedef struct packed {
    logic [63:0] group_bytes;
    logic        group_valid;
    logic [1:0]  status;
    logic        message_end;
    logic        last_of_input;
  } result_t;

  typedef struct packed {
    logic                       restart;
    logic [PACKED_LENGTH_W-1:0] length;
    logic [OUTPUT_LIMIT_W-1:0]  limit;
  } cfg_ctrl_t;

  // byte lane of the lowest set bit of a header bitmap
  function automatic logic [2:0] low_set_idx(input logic [7:0] bits);
    logic [2:0] idx;
    idx = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (bits[k]) begin
        idx = 3'(k);
      end
    end
    return idx;
  endfunction

endpackage

>>> design/zero_suppression_unpacker.sv
// ----------------------------------------------------------------------------
// zero_suppression_unpacker
// expands a zero-suppressed byte stream into 8-byte groups
// ----------------------------------------------------------------------------
// Usage: write packed_length (index 0) to start a message; output_limit
// (index 1) is picked up at the next start. Packed bytes enter on the input
// valid/ready channel, one request per cycle while input ready is high. Each
// byte yields zero, one or two result requests on the output channel (group,
// status, end flags), queued when the byte is taken. Throughput: one byte per
// clock while input ready is high; the decode state updates once per byte, and
// only the final byte of a message can yield two results. A four-entry result
// queue sits between decode and the output port; input ready drops when fewer
// than two entries are free, so a stalled receiver back-pressures the input
// once more than two results are queued.
// Reset: length 0 (all bytes dropped until a length write), output limit
// 8388608, queue empty. After a status error or the message end, bytes are
// taken and dropped until the next length write.
// ----------------------------------------------------------------------------
module zero_suppression_unpacker import zsu_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             packed_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [63:0]            group_bytes_o,
  output logic                   group_valid_o,
  output logic [1:0]             status_o,
  output logic                   message_end_o,
  output logic                   last_of_input_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [OUTPUT_LIMIT_W-1:0] limit_q, limit_d;
  cfg_ctrl_t                 ctrl;
  logic                      cfg_fire;
  logic                      in_fire;
  logic                      res0_valid, res1_valid;
  result_t                   res0, res1;
  result_t                   head;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    limit_d      = limit_q;
    ctrl.restart = 1'b0;
    ctrl.length  = PACKED_LENGTH_W'(cfg_data_i);
    ctrl.limit   = limit_q;
    if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_PACKED_LENGTH: ctrl.restart = 1'b1;
        REG_OUTPUT_LIMIT:  limit_d = OUTPUT_LIMIT_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= OUTPUT_LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  zsu_decoder #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_fire_i   (in_fire),
    .byte_i      (packed_byte_i),
    .res0_valid_o(res0_valid),
    .res0_o      (res0),
    .res1_valid_o(res1_valid),
    .res1_o      (res1)
  );

  zsu_result_fifo u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push0_i    (res0_valid),
    .data0_i    (res0),
    .push1_i    (res1_valid),
    .data1_i    (res1),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head)
  );

  assign group_bytes_o   = head.group_bytes;
  assign group_valid_o   = head.group_valid;
  assign status_o        = head.status;
  assign message_end_o   = head.message_end;
  assign last_of_input_o = head.last_of_input;

endmodule

>>> design/zsu_decoder.sv
// ----------------------------------------------------------------------------
// zsu_decoder
// decode state and per-byte result generation, up to two results per byte
// ----------------------------------------------------------------------------
module zsu_decoder import zsu_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_ctrl_t ctrl_i,
  input  logic      in_fire_i,
  input  logic [7:0] byte_i,
  output logic      res0_valid_o,
  output result_t   res0_o,
  output logic      res1_valid_o,
  output result_t   res1_o
);

  localparam int unsigned CmpW = (LENGTH_BITS > RUN_W) ? LENGTH_BITS : RUN_W;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_DATA   = 3'd1;
  localparam logic [2:0] PH_COUNT  = 3'd2;
  localparam logic [2:0] PH_RUN    = 3'd3;
  localparam logic [2:0] PH_HALT   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  logic [2:0]                ph_q, ph_d;
  logic [7:0]                pend_q, pend_d;
  logic [63:0]               buf_q, buf_d;
  logic [2:0]                fill_q, fill_d;
  logic [LENGTH_BITS-1:0]    msg_q, msg_d;
  logic [OUTPUT_LIMIT_W-1:0] space_q, space_d;
  logic [RUN_W-1:0]          run_q, run_d;
  logic                      full_q, full_d;

  logic [LENGTH_BITS-1:0] msg_dec;
  logic                   is_last;
  logic                   active;
  logic                   end_flag;
  logic [2:0]             lane;
  logic [7:0]             pend_clr;
  logic [63:0]            data_buf;
  logic [63:0]            run_buf;
  logic [RUN_W-1:0]       cnt8;
  logic [RUN_W-1:0]       cntm8;
  logic [RUN_W-1:0]       run_dec;
  logic [2:0]             fill_inc;
  logic [3:0]             gap;
  logic [RUN_W-1:0]       run_rest;
  result_t                r0, r1;
  logic                   r0v, r1v;

  always_comb begin
    ph_d    = ph_q;
    pend_d  = pend_q;
    buf_d   = buf_q;
    fill_d  = fill_q;
    msg_d   = msg_q;
    space_d = space_q;
    run_d   = run_q;
    full_d  = full_q;
    r0      = '0;
    r1      = '0;
    r0v     = 1'b0;
    r1v     = 1'b0;

    msg_dec  = msg_q - 1'b1;
    is_last  = (msg_dec == '0);
    active   = in_fire_i && (ph_q != PH_HALT) && (ph_q != PH_DONE) && (msg_q != '0);
    end_flag = 1'b0;

    lane     = low_set_idx(pend_q);
    pend_clr = pend_q & (pend_q - 8'd1);
    data_buf = (pend_q != 8'd0) ? (buf_q | (64'(byte_i) << {lane, 3'b000})) : buf_q;
    run_buf  = buf_q | (64'(byte_i) << {fill_q, 3'b000});
    cnt8     = {byte_i, 3'b000};
    cntm8    = {byte_i - 8'd1, 3'b000};
    run_dec  = (run_q != '0) ? run_q - 1'b1 : '0;
    fill_inc = fill_q + 3'd1;
    gap      = 4'd8 - {1'b0, fill_inc};
    run_rest = (run_dec > RUN_W'(gap)) ? run_dec - RUN_W'(gap) : '0;

    if (active) begin
      msg_d = msg_dec;
      unique case (ph_q)
        PH_HEADER: begin
          if (space_q < OUTPUT_LIMIT_W'(8)) begin
            r0v       = 1'b1;
            r0.status = ST_NO_SPACE;
            ph_d      = PH_HALT;
          end else begin
            space_d = space_q - OUTPUT_LIMIT_W'(8);
            buf_d   = '0;
            pend_d  = byte_i;
            full_d  = (byte_i == 8'hFF);
            if ((byte_i == 8'd0) || is_last) begin
              r0v            = 1'b1;
              r0.group_valid = 1'b1;
            end else begin
              ph_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          buf_d  = data_buf;
          pend_d = pend_clr;
          if ((pend_clr == 8'd0) || is_last) begin
            r0v            = 1'b1;
            r0.group_valid = 1'b1;
            r0.group_bytes = data_buf;
            ph_d = ((pend_clr == 8'd0) && full_q) ? PH_COUNT : PH_HEADER;
          end
        end
        PH_COUNT: begin
          if (!is_last) begin
            if (byte_i == 8'd0) begin
              ph_d = PH_HEADER;
            end else if (CmpW'(cntm8) > CmpW'(msg_dec)) begin
              r0v       = 1'b1;
              r0.status = ST_BAD_COUNT;
              ph_d      = PH_HALT;
            end else if (OUTPUT_LIMIT_W'(cnt8) > space_q) begin
              r0v       = 1'b1;
              r0.status = ST_NO_SPACE;
              ph_d      = PH_HALT;
            end else begin
              space_d = space_q - OUTPUT_LIMIT_W'(cnt8);
              run_d   = cnt8;
              fill_d  = 3'd0;
              buf_d   = '0;
              ph_d    = PH_RUN;
            end
          end
        end
        PH_RUN: begin
          run_d = run_dec;
          if (fill_q == 3'd7) begin
            // group complete
            r0v            = 1'b1;
            r0.group_valid = 1'b1;
            r0.group_bytes = run_buf;
            buf_d          = '0;
            fill_d         = 3'd0;
          end else begin
            buf_d  = run_buf;
            fill_d = fill_inc;
          end
          if (run_dec == '0) begin
            ph_d = PH_HEADER;
          end else if (is_last) begin
            // message ends inside the run: zero-fill the remainder
            if (fill_q == 3'd7) begin
              r1v            = 1'b1;
              r1.group_valid = 1'b1;
            end else begin
              r0v            = 1'b1;
              r0.group_valid = 1'b1;
              r0.group_bytes = run_buf;
              if (run_rest != '0) begin
                r1v            = 1'b1;
                r1.group_valid = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase

      end_flag = is_last || (ph_d == PH_HALT);
      if (is_last && (ph_d != PH_HALT)) begin
        if (!r0v) begin
          r0v = 1'b1;
          r0  = '0;
        end
        ph_d = PH_DONE;
      end
      if (r1v) begin
        r1.message_end   = end_flag;
        r1.last_of_input = 1'b1;
      end else if (r0v) begin
        r0.message_end   = end_flag;
        r0.last_of_input = 1'b1;
      end
    end

    if (ctrl_i.restart) begin
      ph_d    = PH_HEADER;
      pend_d  = '0;
      buf_d   = '0;
      fill_d  = '0;
      msg_d   = LENGTH_BITS'(ctrl_i.length);
      space_d = ctrl_i.limit;
      run_d   = '0;
      full_d  = 1'b0;
      r0v     = 1'b0;
      r1v     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_HEADER;
      pend_q  <= '0;
      buf_q   <= '0;
      fill_q  <= '0;
      msg_q   <= '0;
      space_q <= OUTPUT_LIMIT_RESET;
      run_q   <= '0;
      full_q  <= 1'b0;
    end else begin
      ph_q    <= ph_d;
      pend_q  <= pend_d;
      buf_q   <= buf_d;
      fill_q  <= fill_d;
      msg_q   <= msg_d;
      space_q <= space_d;
      run_q   <= run_d;
      full_q  <= full_d;
    end
  end

  assign res0_valid_o = r0v;
  assign res0_o       = r0;
  assign res1_valid_o = r1v;
  assign res1_o       = r1;

endmodule

>>> design/zsu_result_fifo.sv
// ----------------------------------------------------------------------------
// zsu_result_fifo
// small result queue, takes up to two results per cycle, hands out one
// ----------------------------------------------------------------------------
module zsu_result_fifo import zsu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push0_i,
  input  result_t data0_i,
  input  logic    push1_i,
  input  result_t data1_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t head_o
);

  localparam int unsigned PtrW = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  result_t         mem_q [RES_FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_next;
  logic            pop;

  assign pop     = out_valid_o && out_ready_i;
  assign wr_next = PtrW'(wr_q + 1'b1);

  always_comb begin
    wr_d  = wr_q + PtrW'(push0_i) + PtrW'(push1_i);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push0_i) + CntW'(push1_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_next] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // room for a byte that yields two results
  assign room_o      = (cnt_q <= CntW'(RES_FIFO_DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];

endmodule

>>> design/zsu_checker.sv
// ----------------------------------------------------------------------------
// zsu_checker
// port-level checks of the zero suppression unpacker, bound to the top level
// ----------------------------------------------------------------------------
`include "zero_suppression_unpacker_macros.svh"

module zsu_checker import zsu_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [63:0]            group_bytes_o,
  input logic                   group_valid_o,
  input logic [1:0]             status_o,
  input logic                   message_end_o,
  input logic                   last_of_input_o
);

  // a stalled result request holds
  `ZSU_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(group_bytes_o) && $stable(status_o), "result changed while stalled")

  // error results carry no group and close the message
  `ZSU_ASSERT_IMP(a_err_closes, out_valid_o && (status_o != ST_OK),
    message_end_o && last_of_input_o && !group_valid_o, "error result not terminal")

  // bytes without a group are zero
  `ZSU_ASSERT_IMP(a_empty_zero, out_valid_o && !group_valid_o,
    group_bytes_o == 64'd0, "nonzero bytes without group")

  // status code three is never produced
  `ZSU_ASSERT(a_status_code, !out_valid_o || (status_o != 2'd3), "unknown status code")

endmodule

bind zero_suppression_unpacker zsu_checker u_zsu_checker (.*);

>>> bench/zsu_group_checker.sv
// ----------------------------------------------------------------------------
// zsu_group_checker
// watches the byte, result and register channels of the unpacker, predicts
// the 8-byte groups and status of each accepted byte and compares them in order
// ----------------------------------------------------------------------------
module zsu_group_checker import zsu_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [7:0]             packed_byte_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [63:0]            group_bytes_i,
  input  logic                   group_valid_i,
  input  logic [1:0]             status_i,
  input  logic                   message_end_i,
  input  logic                   last_of_input_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     mismatch_count_o,
  output int                     pending_o
);

  typedef enum logic [2:0] {
    WAIT_HEADER,
    WAIT_DATA,
    WAIT_COUNT,
    IN_RUN,
    STOPPED,
    ENDED
  } dec_state_e;

  dec_state_e                 dec_state;
  logic [7:0]                 bitmap_left;
  logic [63:0]                lane_word;
  logic [3:0]                 run_fill;
  logic [LENGTH_BITS_DEF-1:0] bytes_left;
  logic [OUTPUT_LIMIT_W-1:0]  room_left;
  logic [RUN_W-1:0]           run_bytes_left;
  logic                       full_map;
  logic [PACKED_LENGTH_W-1:0] length_reg;
  logic [OUTPUT_LIMIT_W-1:0]  limit_reg;

  result_t expected_groups [$];
  result_t want;
  int      mismatches;

  function automatic result_t make_result(input logic [63:0] g, input logic v,
                                          input logic [1:0] st);
    result_t r;
    r.group_bytes   = g;
    r.group_valid   = v;
    r.status        = st;
    r.message_end   = 1'b0;
    r.last_of_input = 1'b0;
    return r;
  endfunction

  function automatic void reload_message();
    dec_state      = WAIT_HEADER;
    bitmap_left    = '0;
    lane_word      = '0;
    run_fill       = '0;
    bytes_left     = length_reg;
    room_left      = limit_reg;
    run_bytes_left = '0;
    full_map       = 1'b0;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] exp_val);
    if (mismatches < 40) begin
      $display("%0t mismatch %s: got %h want %h", $time, what, got, exp_val);
    end
    mismatches++;
  endtask

  // decode one accepted byte and queue the results it yields
  task automatic expand_byte(input logic [7:0] b);
    result_t outs [$];
    logic    fin;
    int      lane;
    int      gap;
    if (dec_state == STOPPED || dec_state == ENDED || bytes_left == 0) begin
      return;
    end
    bytes_left = bytes_left - 1'b1;
    fin = (bytes_left == 0);
    case (dec_state)
      WAIT_HEADER: begin
        if (room_left < 8) begin
          outs.push_back(make_result(64'd0, 1'b0, ST_NO_SPACE));
          dec_state = STOPPED;
        end else begin
          room_left   = room_left - 24'd8;
          lane_word   = '0;
          bitmap_left = b;
          full_map    = (b == 8'hFF);
          if (b == 8'h00 || fin) begin
            outs.push_back(make_result(lane_word, 1'b1, ST_OK));
          end else begin
            dec_state = WAIT_DATA;
          end
        end
      end
      WAIT_DATA: begin
        if (bitmap_left != 0) begin
          lane = 0;
          while (!bitmap_left[lane]) lane++;
          lane_word[8*lane +: 8] = lane_word[8*lane +: 8] | b;
          bitmap_left = bitmap_left & (bitmap_left - 8'd1);
        end
        if (bitmap_left == 0 || fin) begin
          outs.push_back(make_result(lane_word, 1'b1, ST_OK));
          dec_state = (bitmap_left == 0 && full_map) ? WAIT_COUNT : WAIT_HEADER;
        end
      end
      WAIT_COUNT: begin
        // a count that closes the message is taken without checks
        if (!fin) begin
          if (b == 8'h00) begin
            dec_state = WAIT_HEADER;
          end else if ((int'(b) - 1) * 8 > int'(bytes_left)) begin
            outs.push_back(make_result(64'd0, 1'b0, ST_BAD_COUNT));
            dec_state = STOPPED;
          end else if (int'(b) * 8 > int'(room_left)) begin
            outs.push_back(make_result(64'd0, 1'b0, ST_NO_SPACE));
            dec_state = STOPPED;
          end else begin
            room_left      = OUTPUT_LIMIT_W'(int'(room_left) - int'(b) * 8);
            run_bytes_left = RUN_W'(int'(b) * 8);
            run_fill       = '0;
            lane_word      = '0;
            dec_state      = IN_RUN;
          end
        end
      end
      IN_RUN: begin
        lane_word[8*run_fill[2:0] +: 8] = lane_word[8*run_fill[2:0] +: 8] | b;
        run_fill++;
        if (run_bytes_left > 0) run_bytes_left--;
        if (run_fill >= 4'd8) begin
          outs.push_back(make_result(lane_word, 1'b1, ST_OK));
          run_fill  = '0;
          lane_word = '0;
        end
        if (run_bytes_left == 0) begin
          dec_state = WAIT_HEADER;
        end else if (fin) begin
          // message cut inside a run: zero-fill what is left
          while (run_bytes_left > 0 && outs.size() < 2) begin
            gap = 8 - int'(run_fill);
            outs.push_back(make_result(lane_word, 1'b1, ST_OK));
            run_bytes_left = (int'(run_bytes_left) > gap) ?
                             RUN_W'(int'(run_bytes_left) - gap) : '0;
            run_fill  = '0;
            lane_word = '0;
          end
        end
      end
      default: begin
      end
    endcase
    if (dec_state == STOPPED) begin
      outs[outs.size()-1].message_end = 1'b1;
    end else if (fin) begin
      if (outs.size() == 0) outs.push_back(make_result(64'd0, 1'b0, ST_OK));
      outs[outs.size()-1].message_end = 1'b1;
      dec_state = ENDED;
    end
    if (outs.size() > 0) outs[outs.size()-1].last_of_input = 1'b1;
    foreach (outs[k]) expected_groups.push_back(outs[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_reg = '0;
      limit_reg  = OUTPUT_LIMIT_RESET;
      reload_message();
      expected_groups.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_groups.size() == 0) begin
          flag_mismatch("result with nothing expected", group_bytes_i, 64'd0);
        end else begin
          want = expected_groups.pop_front();
          if (group_bytes_i !== want.group_bytes)
            flag_mismatch("group_bytes", group_bytes_i, want.group_bytes);
          if (group_valid_i !== want.group_valid)
            flag_mismatch("group_valid", 64'(group_valid_i), 64'(want.group_valid));
          if (status_i !== want.status)
            flag_mismatch("status", 64'(status_i), 64'(want.status));
          if (message_end_i !== want.message_end)
            flag_mismatch("message_end", 64'(message_end_i), 64'(want.message_end));
          if (last_of_input_i !== want.last_of_input)
            flag_mismatch("last_of_input", 64'(last_of_input_i),
                          64'(want.last_of_input));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_PACKED_LENGTH) begin
          length_reg = cfg_data_i[PACKED_LENGTH_W-1:0];
          reload_message();
        end else if (cfg_index_i == REG_OUTPUT_LIMIT) begin
          limit_reg = cfg_data_i[OUTPUT_LIMIT_W-1:0];
        end
      end
      if (in_valid_i && in_ready_i) expand_byte(packed_byte_i);
      mismatch_count_o <= mismatches;
      pending_o        <= expected_groups.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives packed messages, register writes and output stalls into the
// zero suppression unpacker; the group checker predicts and compares
// ----------------------------------------------------------------------------
module tb_top;
  import zsu_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int ITEM_TARGET  = 1900;
  localparam int MAX_LENGTH   = (1 << PACKED_LENGTH_W) - 1;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [7:0]             packed_byte = '0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [63:0]            group_bytes;
  logic                   group_valid;
  logic [1:0]             status;
  logic                   message_end;
  logic                   last_of_input;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  int mismatch_count;
  int pending;

  logic [7:0] msg_q [$];
  int         burst_left = 0;
  int         items_sent = 0;
  int         cur_limit  = int'(OUTPUT_LIMIT_RESET);
  int         idle_cycles = 0;

  zero_suppression_unpacker u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .packed_byte_i  (packed_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .group_bytes_o  (group_bytes),
    .group_valid_o  (group_valid),
    .status_o       (status),
    .message_end_o  (message_end),
    .last_of_input_o(last_of_input),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  zsu_group_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .packed_byte_i   (packed_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .group_bytes_i   (group_bytes),
    .group_valid_i   (group_valid),
    .status_i        (status),
    .message_end_i   (message_end),
    .last_of_input_i (last_of_input),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no request on any channel for too long means the block hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern, with long hold-offs to fill the result queue
  initial begin : rx_pattern
    int stretch;
    int mode;
    int len;
    stretch = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 200);
      if (stretch == 8 || $urandom_range(0, 49) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(250, 400)) @(posedge clk);
      end else begin
        repeat (len) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ~out_ready;
          endcase
          @(posedge clk);
        end
      end
      stretch++;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) :
                   $urandom_range(1, 12);
    end
    in_valid    <= 1'b1;
    packed_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // registers only change once every expected result is out
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_OUTPUT_LIMIT) cur_limit = value;
  endtask

  task automatic play_message(input int length, input int n_send);
    write_reg(REG_PACKED_LENGTH, length);
    for (int i = 0; i < n_send; i++) begin
      send_byte((i < msg_q.size()) ? msg_q[i] : 8'($urandom_range(0, 255)));
    end
    items_sent += (length < n_send) ? length : n_send;
  endtask

  // well-formed groups with random content, some runs cut short
  task automatic build_message(input int groups);
    logic [7:0] hdr;
    int         sel;
    int         cnt;
    int         run_len;
    bit         last_grp;
    for (int g = 0; g < groups; g++) begin
      last_grp = (g == groups - 1);
      sel = $urandom_range(0, 19);
      hdr = (sel == 0) ? 8'h00 : (sel < 6) ? 8'hFF : 8'($urandom_range(1, 255));
      msg_q.push_back(hdr);
      repeat ($countones(hdr)) msg_q.push_back(8'($urandom_range(0, 255)));
      if (hdr == 8'hFF && (!last_grp || $urandom_range(0, 3) == 0)) begin
        sel = $urandom_range(0, 19);
        cnt = (sel < 3) ? 0 : (sel == 3) ? 255 : $urandom_range(1, 4);
        run_len = cnt * 8;
        if (sel == 4 || sel == 5) run_len -= $urandom_range(1, 8);
        else if (sel == 6) run_len -= $urandom_range(9, 16);
        if (run_len < 0 || (sel == 3 && $urandom_range(0, 1) == 0)) run_len = 0;
        msg_q.push_back(8'(cnt));
        // count as the closing byte of the message
        if (last_grp && sel == 7) run_len = 0;
        repeat (run_len) msg_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int pick;
    int length;
    int n_send;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message
    msg_q = {8'h5A};
    play_message(0, 1);
    // zero header closing the message
    msg_q = {8'h00};
    play_message(1, 1);
    // message ends before all set lanes are filled
    msg_q = {8'h81, 8'hAA};
    play_message(2, 2);
    // full group then count as last byte
    msg_q = {8'hFF, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h03};
    play_message(10, 10);
    // header with no output space left
    write_reg(REG_OUTPUT_LIMIT, 0);
    msg_q = {8'h01, 8'h5A};
    play_message(2, 2);
    write_reg(REG_OUTPUT_LIMIT, int'(OUTPUT_LIMIT_RESET));
    // run count larger than the rest of the message
    msg_q = {8'hFF, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
             8'h05, 8'h00};
    play_message(11, 11);
    // longest message length, left open
    msg_q = {8'h00, 8'h01};
    play_message(MAX_LENGTH, 2);

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        case ($urandom_range(0, 5))
          0: write_reg(REG_OUTPUT_LIMIT, 0);
          1: write_reg(REG_OUTPUT_LIMIT, $urandom_range(1, 7));
          2: write_reg(REG_OUTPUT_LIMIT, $urandom_range(8, 120));
          3: write_reg(REG_OUTPUT_LIMIT, $urandom_range(0, int'(OUTPUT_LIMIT_RESET)));
          default: write_reg(REG_OUTPUT_LIMIT, int'(OUTPUT_LIMIT_RESET));
        endcase
      end
      msg_q.delete();
      if (pick < 85) begin
        build_message($urandom_range(1, 6));
      end else begin
        repeat ($urandom_range(1, 24)) msg_q.push_back(8'($urandom_range(0, 255)));
      end
      length = msg_q.size();
      pick = $urandom_range(0, 99);
      if (pick < 20) length = $urandom_range(1, msg_q.size());
      else if (pick < 22) length = 0;
      else if (pick < 24) length = MAX_LENGTH;
      n_send = msg_q.size();
      if ($urandom_range(0, 9) == 0) n_send += $urandom_range(1, 4);
      if ($urandom_range(0, 24) == 0) n_send = $urandom_range(0, msg_q.size());
      play_message(length, n_send);
      if (cur_limit < 4096 && $urandom_range(0, 1) == 0) begin
        write_reg(REG_OUTPUT_LIMIT, int'(OUTPUT_LIMIT_RESET));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
